@@ rtl/core/pff_pkg.sv @@
// Types and constants for the phase field face flux block.
`timescale 1ns / 1ps
package pff_pkg;

  localparam int AddrWidth = 5;
  localparam int DataWidth = 32;

  typedef enum logic [2:0] {
    REG_MOB_COMP = 3'd0,
    REG_MOB_SURF = 3'd1,
    REG_SURF_MODE = 3'd2,
    REG_SOLID = 3'd3,
    REG_ADS_EN = 3'd4,
    REG_ADS_RATE = 3'd5,
    REG_DES_RATE = 3'd6,
    REG_INV_CAP = 3'd7
  } pff_reg_e;

  typedef struct packed {
    logic [30:0]        mobility_composition;
    logic [30:0]        mobility_surfactant;
    logic               surfactant_mode;
    logic               solid_present;
    logic               adsorption_enable;
    logic signed [31:0] adsorption_rate;
    logic signed [31:0] desorption_rate;
    logic signed [31:0] inverse_capacity;
  } pff_cfg_t;

  typedef struct packed {
    logic signed [31:0] advective_flux_comp;
    logic signed [31:0] advective_flux_surf;
    logic signed [31:0] potential_comp_here;
    logic signed [31:0] potential_comp_there;
    logic signed [31:0] potential_surf_here;
    logic signed [31:0] potential_surf_there;
    logic signed [31:0] composition_here;
    logic signed [31:0] composition_there;
    logic signed [31:0] surfactant_here;
    logic signed [31:0] surfactant_there;
    logic [1:0]         fluid_flags;
  } pff_in_t;

  typedef struct packed {
    logic signed [31:0] face_flux_comp;
    logic signed [31:0] face_flux_surf;
    logic               saturated;
  } pff_out_t;

endpackage

@@ rtl/core/pff_in_if.sv @@
// Input channel carrying one face beat.
`timescale 1ns / 1ps
interface pff_in_if import pff_pkg::*; ();
  logic    valid;
  logic    ready;
  pff_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/pff_out_if.sv @@
// Output channel carrying one flux beat.
`timescale 1ns / 1ps
interface pff_out_if import pff_pkg::*; ();
  logic     valid;
  logic     ready;
  pff_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/pff_cfg.sv @@
// APB register file holding the block configuration.
`timescale 1ns / 1ps
module pff_cfg import pff_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output pff_cfg_t             cfg_o
);

  pff_cfg_t   cfg_q, cfg_d;
  logic       wr_en;
  pff_reg_e   idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = pff_reg_e'(paddr[AddrWidth-1:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MOB_COMP:  cfg_d.mobility_composition = pwdata[30:0];
        REG_MOB_SURF:  cfg_d.mobility_surfactant  = pwdata[30:0];
        REG_SURF_MODE: cfg_d.surfactant_mode      = pwdata[0];
        REG_SOLID:     cfg_d.solid_present        = pwdata[0];
        REG_ADS_EN:    cfg_d.adsorption_enable    = pwdata[0];
        REG_ADS_RATE:  cfg_d.adsorption_rate      = signed'(pwdata);
        REG_DES_RATE:  cfg_d.desorption_rate      = signed'(pwdata);
        REG_INV_CAP:   cfg_d.inverse_capacity     = signed'(pwdata);
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MOB_COMP:  prdata = {1'b0, cfg_q.mobility_composition};
      REG_MOB_SURF:  prdata = {1'b0, cfg_q.mobility_surfactant};
      REG_SURF_MODE: prdata = {31'd0, cfg_q.surfactant_mode};
      REG_SOLID:     prdata = {31'd0, cfg_q.solid_present};
      REG_ADS_EN:    prdata = {31'd0, cfg_q.adsorption_enable};
      REG_ADS_RATE:  prdata = cfg_q.adsorption_rate;
      REG_DES_RATE:  prdata = cfg_q.desorption_rate;
      REG_INV_CAP:   prdata = cfg_q.inverse_capacity;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      cfg_q.inverse_capacity <= 32'(64'd1 << FRAC_BITS);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/core/pff_datapath.sv @@
// Four-stage flux pipeline: products, round and remultiply, remultiply, final sums.
`timescale 1ns / 1ps
module pff_datapath import pff_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pff_cfg_t cfg_i,
  pff_in_if.sink   face_i,
  pff_out_if.source flux_o
);

  localparam int PW = 72;
  localparam logic signed [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] ONE  = HALF <<< 1;
  localparam logic signed [PW-1:0] SMAX = PW'(32'sh7fffffff);
  localparam logic signed [PW-1:0] SMIN = -SMAX - 1;

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] x);
    return (x + HALF) >>> FRAC_BITS;
  endfunction

  // bit 32 flags a clip
  function automatic logic [32:0] sat(input logic signed [PW-1:0] x);
    if (x > SMAX) return {1'b1, 32'h7fffffff};
    else if (x < SMIN) return {1'b1, 32'h80000000};
    else return {1'b0, x[31:0]};
  endfunction

  // ---------------- stage 1 ----------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || flux_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign face_i.ready = rdy1;

  pff_in_t in;
  logic signed [32:0] dmu, dnu, ssum;
  logic signed [31:0] p, sa, sb, phi;
  logic [32:0]        q_s;
  logic               lowf;

  assign in   = face_i.data;
  assign lowf = in.fluid_flags[0];
  assign dmu  = 33'(in.potential_comp_there) - 33'(in.potential_comp_here);
  assign dnu  = 33'(in.potential_surf_there) - 33'(in.potential_surf_here);
  assign ssum = 33'(in.surfactant_here) + 33'(in.surfactant_there);
  assign p    = ssum[32:1];
  assign q_s  = sat(ONE - PW'(p));
  assign sa   = lowf ? in.surfactant_here : in.surfactant_there;
  assign sb   = lowf ? in.surfactant_there : in.surfactant_here;
  assign phi  = lowf ? in.composition_here : in.composition_there;

  logic signed [31:0] adv_c1_q, adv_s1_q, sb1_q;
  logic signed [32:0] dnu1_q;
  logic [1:0]         flg1_q;
  logic               cq1_q;
  logic signed [64:0] pc1_q;
  logic signed [63:0] gp1_q, rsp1_q, a1p1_q, kmp1_q, sqp1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (rdy1) v1_q <= face_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      adv_c1_q <= in.advective_flux_comp;
      adv_s1_q <= in.advective_flux_surf;
      sb1_q    <= sb;
      dnu1_q   <= dnu;
      flg1_q   <= in.fluid_flags;
      cq1_q    <= q_s[32];
      pc1_q    <= $signed({1'b0, cfg_i.mobility_composition}) * dmu;
      gp1_q    <= p * $signed(q_s[31:0]);
      rsp1_q   <= cfg_i.inverse_capacity * sb;
      a1p1_q   <= cfg_i.adsorption_rate * sa;
      kmp1_q   <= cfg_i.desorption_rate * cfg_i.inverse_capacity;
      sqp1_q   <= phi * phi;
    end
  end

  // ---------------- stage 2 ----------------
  logic [32:0] dc_s, fc_s, g_s, t1_s, fr_s, a1_s, km_s;
  logic signed [PW-1:0] sq;
  logic signed [32:0]   tc;

  assign dc_s = sat(-rnd(PW'(pc1_q)));
  assign fc_s = sat(PW'(adv_c1_q) + PW'($signed(dc_s[31:0])));
  assign g_s  = sat(rnd(PW'(gp1_q)));
  assign t1_s = sat(rnd(PW'(rsp1_q)));
  assign fr_s = sat(ONE - PW'($signed(t1_s[31:0])));
  assign a1_s = sat(rnd(PW'(a1p1_q)));
  assign km_s = sat(rnd(PW'(kmp1_q)));
  assign sq   = rnd(PW'(sqp1_q));
  assign tc   = (sq >= ONE) ? 33'sd0 : 33'(ONE - sq);

  logic signed [31:0] fc2_q, adv_s2_q;
  logic               cc2_q, cs2_q, ca2_q;
  logic signed [32:0] dnu2_q, tc2_q;
  logic [1:0]         flg2_q;
  logic signed [63:0] mp2_q, adsp2_q, desp2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (rdy2) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      fc2_q    <= fc_s[31:0];
      cc2_q    <= dc_s[32] | fc_s[32];
      adv_s2_q <= adv_s1_q;
      cs2_q    <= cq1_q | g_s[32];
      ca2_q    <= t1_s[32] | fr_s[32] | a1_s[32] | km_s[32];
      dnu2_q   <= dnu1_q;
      tc2_q    <= tc;
      flg2_q   <= flg1_q;
      mp2_q    <= $signed({1'b0, cfg_i.mobility_surfactant}) * $signed(g_s[31:0]);
      adsp2_q  <= $signed(a1_s[31:0]) * $signed(fr_s[31:0]);
      desp2_q  <= $signed(km_s[31:0]) * sb1_q;
    end
  end

  // ---------------- stage 3 ----------------
  logic [32:0] m_s, ad_s, de_s, h_s;

  assign m_s  = sat(rnd(PW'(mp2_q)));
  assign ad_s = sat(rnd(PW'(adsp2_q)));
  assign de_s = sat(rnd(PW'(desp2_q)));
  assign h_s  = sat(PW'($signed(ad_s[31:0])) - PW'($signed(de_s[31:0])));

  logic signed [31:0] fc3_q, adv_s3_q;
  logic               cc3_q, cs3_q, ca3_q;
  logic [1:0]         flg3_q;
  logic signed [64:0] dp3_q, hp3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (rdy3) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      fc3_q    <= fc2_q;
      cc3_q    <= cc2_q;
      adv_s3_q <= adv_s2_q;
      cs3_q    <= cs2_q | m_s[32];
      ca3_q    <= ca2_q | ad_s[32] | de_s[32] | h_s[32];
      flg3_q   <= flg2_q;
      dp3_q    <= $signed(m_s[31:0]) * dnu2_q;
      hp3_q    <= tc2_q * $signed(h_s[31:0]);
    end
  end

  // ---------------- stage 4: sums, masking, output register ----------------
  logic [32:0]          ds_s, fs_s, fa_s;
  logic signed [PW-1:0] hr;
  logic                 both_fluid, masked, keep_surf;
  pff_out_t             out_d, out_q;

  assign ds_s = sat(-rnd(PW'(dp3_q)));
  assign fs_s = sat(PW'(adv_s3_q) + PW'($signed(ds_s[31:0])));
  assign hr   = rnd(PW'(hp3_q));
  assign fa_s = sat(flg3_q[0] ? hr : -hr);

  assign both_fluid = &flg3_q;
  assign masked     = (cfg_i.adsorption_enable | cfg_i.solid_present) & !both_fluid;
  assign keep_surf  = cfg_i.surfactant_mode & cfg_i.adsorption_enable & (|flg3_q);

  always_comb begin
    logic cc, cs;
    cc = cc3_q;
    cs = cs3_q | ds_s[32] | fs_s[32];
    out_d.face_flux_comp = fc3_q;
    out_d.face_flux_surf = fs_s[31:0];
    if (masked) begin
      out_d.face_flux_comp = '0;
      cc = 1'b0;
      // with adsorption and surfactant mode on, adsorption replaces the surfactant flux on fluid-solid faces
      out_d.face_flux_surf = keep_surf ? fa_s[31:0] : '0;
      cs = keep_surf & (ca3_q | fa_s[32]);
    end
    if (!cfg_i.surfactant_mode) begin
      out_d.face_flux_surf = '0;
      cs = 1'b0;
    end
    out_d.saturated = cc | cs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (rdy4) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) out_q <= out_d;
  end

  assign flux_o.valid = v4_q;
  assign flux_o.data  = out_q;

endmodule

@@ rtl/core/phase_field_face_flux.sv @@
// Top level of the Cahn-Hilliard face flux pipeline with APB configuration.
`timescale 1ns / 1ps
// Usage:
//   face_i carries one lattice face per beat (advective fluxes, potentials,
//   order parameters and fluid flags); flux_o returns one beat per face with
//   the saturated Q8.24 composition and surfactant fluxes and a clip flag.
//   Beats move on valid and ready both high at a rising clk_i edge.
//   A result passes through the four register stages before it is valid.
//   Throughput: one face per cycle while flux_o is ready; the stages each
//   hold at most one multiply level (products, round and remultiply,
//   remultiply, final sums and masking into the output register).
//   Each stage advances when it is empty or the next one moves, so gaps
//   collapse and a stalled flux_o fills the pipe before face_i drops ready.
//   A stall loses and repeats nothing.
//   Reset (rst_ni low, asynchronous) empties the pipe and sets all configuration
//   registers to zero except inverse capacity, which starts at 1.0.
//   Write the APB registers only while the pipe is empty.
module phase_field_face_flux import pff_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  pff_in_if.sink               face_i,
  pff_out_if.source            flux_o
);

  pff_cfg_t cfg;

  // hold the configuration registers
  pff_cfg #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // compute the fluxes
  pff_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .face_i(face_i),
    .flux_o(flux_o)
  );

endmodule
